// ----- rtl/shell_word_tokenizer_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef SHELL_WORD_TOKENIZER_MACROS_SVH
`define SHELL_WORD_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer next-cycle check failed");

`endif

// ----- rtl/swt_pkg.sv -----
package swt_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_SQ     = 2'd2,
        MODE_DQ     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_SQ   = 2'd1,
        ERR_DQ   = 2'd2
    } t_err;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BEL    = 8'h07;

    // One input item can cause at most this many results.
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0] byte_req;
        logic       has_byte;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       token_end;
        logic       glob_ok;
        logic       line_end;
        logic [1:0] error;
        logic       last;
    } t_result;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] held_byte;
        logic       held_valid;
        logic       word_nonempty;
        logic       glob_flag;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:          MODE_NORMAL,
        held_byte:     8'h00,
        held_valid:    1'b0,
        word_nonempty: 1'b0,
        glob_flag:     1'b1
    };

    // Outcome of deciding one byte: updated state, at most one result and
    // whether the lookahead byte was used up as well.
    typedef struct packed {
        t_state  st;
        logic    emit;
        t_result res;
        logic    consumed;
    } t_decide;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_LF) || (c == CH_BEL);
    endfunction

    function automatic t_decide add_char(input t_decide d_in, input logic [7:0] c,
                                         input logic quoted);
        t_decide d;
        d = d_in;
        d.emit             = 1'b1;
        d.res.out_char     = c;
        d.res.has_char     = 1'b1;
        d.st.word_nonempty = 1'b1;
        if (quoted) begin
            d.st.glob_flag = 1'b0;
        end
        return d;
    endfunction

    function automatic t_decide end_word(input t_decide d_in, input logic force_end);
        t_decide d;
        d = d_in;
        d.emit             = d_in.st.word_nonempty | force_end;
        d.res.token_end    = 1'b1;
        d.res.glob_ok      = d_in.st.glob_flag;
        d.st.word_nonempty = 1'b0;
        d.st.glob_flag     = 1'b1;
        return d;
    endfunction

    function automatic t_decide decide(input t_state st, input logic [7:0] c,
                                       input logic has_next, input logic [7:0] nx);
        t_decide d;
        logic    close_forces;
        d            = '0;
        d.st         = st;
        close_forces = !has_next || is_space(nx);
        case (st.mode)
            MODE_NORMAL: begin
                if (c == CH_BSLASH) begin
                    d.st.mode = MODE_ESC;
                end else if (c == CH_SQUOTE) begin
                    d.st.mode = MODE_SQ;
                end else if (c == CH_DQUOTE) begin
                    d.st.mode = MODE_DQ;
                end else if (is_space(c)) begin
                    d = end_word(d, 1'b0);
                end else begin
                    d = add_char(d, c, 1'b0);
                end
            end
            MODE_ESC: begin
                d = add_char(d, c, 1'b1);
                d.st.mode = MODE_NORMAL;
            end
            MODE_SQ: begin
                if (c == CH_SQUOTE) begin
                    d.st.mode = MODE_NORMAL;
                    if (close_forces) begin
                        d = end_word(d, 1'b1);
                    end
                end else begin
                    d = add_char(d, c, 1'b1);
                end
            end
            MODE_DQ: begin
                if (c == CH_DQUOTE) begin
                    d.st.mode = MODE_NORMAL;
                    if (close_forces) begin
                        d = end_word(d, 1'b1);
                    end
                end else if (c == CH_BSLASH && has_next &&
                             (nx == CH_DQUOTE || nx == CH_BSLASH ||
                              nx == CH_DOLLAR || nx == CH_SPACE)) begin
                    d = add_char(d, nx, 1'b1);
                    d.consumed = 1'b1;
                end else begin
                    d = add_char(d, c, 1'b1);
                end
            end
            default: begin
                d.st.mode = MODE_NORMAL;
            end
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/swt_chan_if.sv -----
interface swt_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/swt_core.sv -----
module swt_core (
    input  swt_pkg::t_state   i_state,
    input  swt_pkg::t_in_item i_item,
    output swt_pkg::t_state   o_state,
    output swt_pkg::t_result  o_res [swt_pkg::MAX_RESULTS],
    output logic [swt_pkg::CNT_W-1:0] o_cnt
);
    import swt_pkg::*;

    t_decide          d_a;
    t_decide          d_b;
    t_state           s_a;
    t_state           s_b;
    t_result          line_res;
    t_result          cand [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] cand_v;
    logic             decide_eol;
    logic [CNT_W-1:0] cnt;

    // The held byte is decided with the new byte as lookahead.
    always_comb begin
        d_a = decide(i_state, i_state.held_byte, 1'b1, i_item.byte_req);
        s_a = i_state;
        if (i_item.has_byte) begin
            if (i_state.held_valid && d_a.consumed) begin
                s_a            = d_a.st;
                s_a.held_valid = 1'b0;
            end else if (i_state.held_valid) begin
                s_a            = d_a.st;
                s_a.held_byte  = i_item.byte_req;
                s_a.held_valid = 1'b1;
            end else begin
                s_a.held_byte  = i_item.byte_req;
                s_a.held_valid = 1'b1;
            end
        end
    end

    // At the end of the line the byte still held is decided with no lookahead.
    assign decide_eol = i_item.end_of_line && s_a.held_valid;

    always_comb begin
        d_b = decide(s_a, s_a.held_byte, 1'b0, 8'h00);
        s_b = decide_eol ? d_b.st : s_a;
    end

    always_comb begin
        line_res          = '0;
        line_res.line_end = 1'b1;
        if (s_b.mode == MODE_SQ) begin
            line_res.error = ERR_SQ;
        end else if (s_b.mode == MODE_DQ) begin
            line_res.error = ERR_DQ;
        end else if (s_b.word_nonempty) begin
            line_res.token_end = 1'b1;
            line_res.glob_ok   = s_b.glob_flag;
        end
    end

    assign cand[0] = d_a.res;
    assign cand[1] = d_b.res;
    assign cand[2] = line_res;
    assign cand_v  = {i_item.end_of_line,
                      decide_eol && d_b.emit,
                      i_item.has_byte && i_state.held_valid && d_a.emit};

    // Pack the valid candidates to the front, in order, and mark the last.
    always_comb begin
        cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_res[i] = '0;
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (cand_v[i]) begin
                o_res[cnt[$clog2(MAX_RESULTS)-1:0]] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        if (cnt != '0) begin
            o_res[cnt[$clog2(MAX_RESULTS)-1:0] - 1'b1].last = 1'b1;
        end
    end

    assign o_cnt   = cnt;
    assign o_state = i_item.end_of_line ? STATE_RESET : s_a;

endmodule

// ----- rtl/shell_word_tokenizer.sv -----
// Shell command-line tokenizer. Characters arrive one per item and leave as a
// stream of word events: one result per word character, a token-end result
// carrying the glob-eligible flag, and one line-end result per line that holds
// an error code when a quote was left open (the consumer then drops the line).
// The tokenizer keeps one byte back as lookahead, so a byte produces its
// result only when the next byte or the end of the line arrives. An item
// causes between zero and three results, which are held in a three-entry
// result buffer that drains one result per cycle while the output is ready.
// A new item is accepted whenever that buffer is empty or its final result
// is being taken in the same cycle, so with the output ready a stream in
// which each item causes at most one result runs at one item per clock;
// items with more results hold off the next item until their earlier results
// have left. There is no configuration and no start-up pass after reset.
`include "shell_word_tokenizer_macros.svh"

module shell_word_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swt_chan_if.sink   i_in_ch,
    swt_chan_if.source o_out_ch
);
    import swt_pkg::*;

    // Parser state: mode, held lookahead byte and the current word's flags.
    t_state           r_state;
    t_state           n_state;

    // Results of the last accepted item; entry 0 is the one on the output.
    t_result          r_buf [MAX_RESULTS];
    t_result          n_buf [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    t_state           core_state;
    t_result          core_res [MAX_RESULTS];
    logic [CNT_W-1:0] core_cnt;

    logic             in_acc;
    logic             out_acc;

    swt_core u_core (
        .i_state (r_state),
        .i_item  (i_in_ch.data),
        .o_state (core_state),
        .o_res   (core_res),
        .o_cnt   (core_cnt)
    );

    // The buffer is free when it is empty or its only remaining result leaves
    // in this cycle.
    assign i_in_ch.ready  = (r_cnt == '0) ||
                            ((r_cnt == CNT_W'(1)) && o_out_ch.ready);
    assign o_out_ch.valid = (r_cnt != '0);
    assign o_out_ch.data  = r_buf[0];

    assign in_acc  = i_in_ch.valid && i_in_ch.ready;
    assign out_acc = o_out_ch.valid && o_out_ch.ready;

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        if (out_acc) begin
            // Shift the remaining results toward the output.
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - 1'b1;
        end
        if (in_acc) begin
            n_state = core_state;
            n_buf   = core_res;
            n_cnt   = core_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    // A new item may only replace the buffer while its final result leaves.
    `SWT_ASSERT_IMPL(a_in_waits_for_drain, i_clk, i_rst_n, in_acc && o_out_ch.valid, out_acc && o_out_ch.data.last)
    // An error code only appears on the closing result of a line.
    `SWT_ASSERT_IMPL(a_error_on_line_end, i_clk, i_rst_n, o_out_ch.valid && (o_out_ch.data.error != ERR_NONE), o_out_ch.data.line_end && o_out_ch.data.last && !o_out_ch.data.token_end)
    // Taking the last result of an item empties the buffer.
    `SWT_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, out_acc && o_out_ch.data.last && !in_acc, !o_out_ch.valid)
    // A byte arriving with nothing held is kept as lookahead.
    `SWT_ASSERT_NEXT(a_byte_held, i_clk, i_rst_n, in_acc && i_in_ch.data.has_byte && !i_in_ch.data.end_of_line && !r_state.held_valid, r_state.held_valid)

endmodule
